>>> hw/rtl/rrv_pkg.sv
// Shared types, widths and constants for the rounded-rectangle vertex generator.
// No dependencies; every other RTL file uses this package.
package rrv_pkg;

   // transaction field widths
   localparam int COORD_W    = 16;   // input rectangle bound, whole pixels
   localparam int XY_W       = 21;   // vertex coordinate, 1/16 pixel
   localparam int VNUM_W     = 6;    // vertex number within a run
   localparam int OFF_W      = 15;   // one offset component, 1/16 pixel
   localparam int TRIG_W     = 16;   // Q1.15 sine / cosine
   localparam int RAD_W      = 16;   // signed radius, 1/16 pixel
   localparam int PROD_W     = TRIG_W + RAD_W;

   // offset RAM
   localparam int TBL_DEPTH  = 64;
   localparam int TBL_AW     = 6;
   localparam int TBL_DW     = 2 * OFF_W;

   // configuration registers
   localparam int RADIUS_W   = 10;
   localparam int SEG_W      = 3;
   localparam int BORDER_W   = 10;
   localparam int CSR_DW     = 32;
   localparam int CSR_AW     = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_CORNER_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENTS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_MODE    = 2'd3;

   localparam logic [RADIUS_W-1:0] RESET_RADIUS   = 10'd8;
   localparam logic [SEG_W-1:0]    RESET_SEGMENTS = 3'd4;
   localparam logic [BORDER_W-1:0] RESET_BORDER   = 10'd2;
   localparam logic                RESET_FRAME    = 1'b0;

   // corner codes, clockwise from top-left
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   // quarter-wave sine polynomial, Q30, odd terms x^11 down to x^1
   localparam longint Q30_ONE  = 64'sd1073741824;
   localparam longint POLY_C11 = -64'sd3864;
   localparam longint POLY_C9  = 64'sd172272;
   localparam longint POLY_C7  = -64'sd5026995;
   localparam longint POLY_C5  = 64'sd85569306;
   localparam longint POLY_C3  = -64'sd693598668;
   localparam longint POLY_C1  = 64'sd1686629713;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_EMIT,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] corner_radius;
      logic [SEG_W-1:0]    segments;
      logic [SEG_W-1:0]    seg_eff;      // clamped to 1..MAX_SEGMENTS
      logic [BORDER_W-1:0] border_width;
      logic                frame_mode;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic              last;           // final entry of a rebuild
      logic [TBL_AW-1:0] addr;
      logic [TBL_DW-1:0] data;           // {y, x}
   } tbl_wr_type;

endpackage

>>> hw/rtl/rrv_if.sv
// Handshake channel interfaces: rectangle requests in, vertex responses out.
// Depends on rrv_pkg for field widths.
interface rrv_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rrv_pkg::COORD_W-1:0] rect_left;
   logic signed [rrv_pkg::COORD_W-1:0] rect_top;
   logic signed [rrv_pkg::COORD_W-1:0] rect_right;
   logic signed [rrv_pkg::COORD_W-1:0] rect_bottom;

   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom,
                   input ready);
   modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom,
                   output ready);
endinterface

interface rrv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [rrv_pkg::XY_W-1:0] vertex_x;
   logic signed [rrv_pkg::XY_W-1:0] vertex_y;
   logic [rrv_pkg::VNUM_W-1:0]      vertex_number;
   logic                            last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_number, last_vertex,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_number, last_vertex,
                   output ready);
endinterface

>>> hw/rtl/rrv_csr.sv
// APB-style configuration registers with readback and segment-count clamping.
// Depends on rrv_pkg.
module rrv_csr #(
   parameter int MAX_SEGMENTS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rrv_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [rrv_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [rrv_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output rrv_pkg::cfg_type              cfg,
   output logic                          cfg_written
);
   import rrv_pkg::*;

   localparam logic [SEG_W-1:0] MAX_SEG = SEG_W'(MAX_SEGMENTS);

   logic [RADIUS_W-1:0]  radius_ff;
   logic [SEG_W-1:0]     seg_ff;
   logic [BORDER_W-1:0]  border_ff;
   logic                 frame_ff;
   logic                 wr;
   logic [CSR_IDX_W-1:0] idx;
   logic [SEG_W-1:0]     seg_eff;

   assign wr          = csr_psel && csr_penable && csr_pwrite;
   assign idx         = csr_paddr[CSR_AW-1:2];
   assign csr_pready  = 1'b1;
   assign cfg_written = wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RESET_RADIUS;
         seg_ff    <= RESET_SEGMENTS;
         border_ff <= RESET_BORDER;
         frame_ff  <= RESET_FRAME;
      end else if (wr) begin
         unique case (idx)
            REG_CORNER_RADIUS: radius_ff <= csr_pwdata[RADIUS_W-1:0];
            REG_SEGMENTS:      seg_ff    <= csr_pwdata[SEG_W-1:0];
            REG_BORDER_WIDTH:  border_ff <= csr_pwdata[BORDER_W-1:0];
            REG_FRAME_MODE:    frame_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (seg_ff == '0) begin
         seg_eff = SEG_W'(1);
      end else if (seg_ff > MAX_SEG) begin
         seg_eff = MAX_SEG;
      end else begin
         seg_eff = seg_ff;
      end
   end

   always_comb begin
      unique case (idx)
         REG_CORNER_RADIUS: csr_prdata = CSR_DW'(radius_ff);
         REG_SEGMENTS:      csr_prdata = CSR_DW'(seg_ff);
         REG_BORDER_WIDTH:  csr_prdata = CSR_DW'(border_ff);
         REG_FRAME_MODE:    csr_prdata = CSR_DW'(frame_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = '{corner_radius: radius_ff, segments: seg_ff, seg_eff: seg_eff,
                  border_width: border_ff, frame_mode: frame_ff};

endmodule

>>> hw/rtl/rrv_builder.sv
// Offset table rebuild sequencer: trig ROM, radius multiply, rounding, RAM write port.
// Depends on rrv_pkg; trig ROM contents are fixed at elaboration from the parameters.
module rrv_builder #(
   parameter int MAX_SEGMENTS     = 6,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rrv_pkg::cfg_type     cfg,
   output rrv_pkg::tbl_wr_type  tbl_wr
);
   import rrv_pkg::*;

   localparam int ROW_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int COL_W = $clog2(4 * MAX_SEGMENTS + 1);
   localparam int ROWS  = 1 << ROW_W;
   localparam int COLS  = 1 << COL_W;

   // Q15 sine at t quarter-turns/D, t in [0, 4D)
   function automatic int sine_q15(input int t);
      longint x;
      longint x2;
      longint acc;
      longint s;
      int     q;
      int     r;
      int     v;
      q = (t / SINE_TABLE_DEPTH) & 3;
      r = t % SINE_TABLE_DEPTH;
      x = (longint'(r) <<< 30) / SINE_TABLE_DEPTH;
      if ((q & 1) != 0) x = Q30_ONE - x;
      x2  = (x * x) / Q30_ONE;
      acc = POLY_C11;
      acc = POLY_C9 + (acc * x2) / Q30_ONE;
      acc = POLY_C7 + (acc * x2) / Q30_ONE;
      acc = POLY_C5 + (acc * x2) / Q30_ONE;
      acc = POLY_C3 + (acc * x2) / Q30_ONE;
      acc = POLY_C1 + (acc * x2) / Q30_ONE;
      s   = (acc * x) / Q30_ONE;
      if (s < 0) s = 0;
      v = int'((s + 64'sd16384) / 64'sd32768);
      if (v > 32767) v = 32767;
      return (q >= 2) ? -v : v;
   endfunction

   logic signed [TRIG_W-1:0] cos_rom [0:ROWS-1][0:COLS-1];
   logic signed [TRIG_W-1:0] sin_rom [0:ROWS-1][0:COLS-1];

   for (genvar gs = 0; gs < ROWS; gs++) begin : g_row
      for (genvar gn = 0; gn < COLS; gn++) begin : g_col
         if (gs < MAX_SEGMENTS && gn <= 4 * (gs + 1)) begin : g_pt
            localparam int SEG = gs + 1;
            localparam int P   = ((gn * SINE_TABLE_DEPTH + 2 * SEG) / (4 * SEG))
                                 % SINE_TABLE_DEPTH;
            localparam int T   = 4 * P;
            localparam int TC  = (T + SINE_TABLE_DEPTH) % (4 * SINE_TABLE_DEPTH);
            localparam logic signed [TRIG_W-1:0] COS_V = TRIG_W'(sine_q15(TC));
            localparam logic signed [TRIG_W-1:0] SIN_V = TRIG_W'(sine_q15(T));
            assign cos_rom[gs][gn] = COS_V;
            assign sin_rom[gs][gn] = SIN_V;
         end else begin : g_pad
            assign cos_rom[gs][gn] = '0;
            assign sin_rom[gs][gn] = '0;
         end
      end
   end

   // sequencer
   logic              busy_ff;
   logic [1:0]        i_ff;
   logic [SEG_W-1:0]  j_ff;
   logic [COL_W-1:0]  n_ff;
   logic              inner_ff;
   logic              wrap_ff;
   logic [TBL_AW-1:0] idx_ff;

   // multiply stage
   logic                     p_vld_ff;
   logic                     p_last_ff;
   logic [TBL_AW-1:0]        p_idx_ff;
   logic signed [PROD_W-1:0] prod_c_ff;
   logic signed [PROD_W-1:0] prod_s_ff;

   logic [SEG_W-1:0]         seg_m1;
   logic [ROW_W-1:0]         row;
   logic signed [RADIUS_W:0] rdiff;
   logic signed [RAD_W-1:0]  r_in;
   logic signed [RAD_W-1:0]  r_out;
   logic signed [RAD_W-1:0]  rad;
   logic signed [TRIG_W-1:0] cos_v;
   logic signed [TRIG_W-1:0] sin_v;
   logic                     step_outer;
   logic                     ends_here;
   logic signed [PROD_W-1:0] w_c;
   logic signed [PROD_W-1:0] w_s;

   assign seg_m1 = cfg.seg_eff - SEG_W'(1);
   assign row    = seg_m1[ROW_W-1:0];
   assign rdiff  = $signed({1'b0, cfg.corner_radius}) - $signed({1'b0, cfg.border_width});
   assign r_in   = {rdiff[RADIUS_W], rdiff, 4'b0000};
   assign r_out  = {2'b00, cfg.corner_radius, 4'b0000};
   assign rad    = inner_ff ? r_in : r_out;
   assign cos_v  = cos_rom[row][n_ff];
   assign sin_v  = sin_rom[row][n_ff];

   // outer point (or the only point) of this angle is being produced
   assign step_outer = !(cfg.frame_mode && inner_ff);
   assign ends_here  = step_outer &&
                       (wrap_ff || (j_ff == cfg.seg_eff && i_ff == 2'd3 && !cfg.frame_mode));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= busy_ff;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && ends_here) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= '0;
         idx_ff   <= '0;
         inner_ff <= cfg.frame_mode;
         wrap_ff  <= 1'b0;
      end else if (busy_ff) begin
         idx_ff <= idx_ff + TBL_AW'(1);
         if (!step_outer) begin
            inner_ff <= 1'b0;
         end else begin
            inner_ff <= cfg.frame_mode;
            if (!wrap_ff) begin
               if (j_ff == cfg.seg_eff) begin
                  j_ff <= '0;
                  if (i_ff == 2'd3) begin
                     wrap_ff <= 1'b1;      // frame mode repeats the first pair
                     n_ff    <= '0;
                  end else begin
                     i_ff <= i_ff + 2'd1;  // shared angle, n stays
                  end
               end else begin
                  j_ff <= j_ff + SEG_W'(1);
                  n_ff <= n_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      p_last_ff <= ends_here;
      p_idx_ff  <= idx_ff;
      prod_c_ff <= cos_v * rad;
      prod_s_ff <= sin_v * rad;
   end

   // offset = floor((-trig*r + 2^14) / 2^15)
   assign w_c = -prod_c_ff + PROD_W'(16384);
   assign w_s = -prod_s_ff + PROD_W'(16384);

   assign tbl_wr = '{we:   p_vld_ff,
                     last: p_last_ff,
                     addr: p_idx_ff,
                     data: {w_s[OFF_W+14:15], w_c[OFF_W+14:15]}};

endmodule

>>> hw/rtl/round_rect_vertex_generator.sv
// Rounded-rectangle vertex generator. One rectangle gives 4(S+1) vertices, 8(S+1)+2 in frame mode.
// A rectangle accepted with a stale table waits for the offset table to be rebuilt first.
// Throughput: one vertex per cycle while the output is not stalled, paced by the single read
// port of the offset RAM; the next rectangle is taken only once the previous one's reads are done.
// Reset (synchronous): control cleared, registers to defaults, table marked stale; the RAM is
// left undefined and is always rebuilt before it is read, so there is no clearing pass.
module round_rect_vertex_generator #(
   parameter int MAX_SEGMENTS     = 6,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   rrv_req_if.sink                    req_bus,
   rrv_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rrv_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rrv_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rrv_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import rrv_pkg::*;

   cfg_type        cfg;
   logic           cfg_written;
   tbl_wr_type     tbl_wr;
   ctrl_state_type state_ff, state_in;

   logic table_valid_ff;
   logic req_ready;
   logic req_acc;
   logic build_start;
   logic issue;
   logic build_done;

   // -------------------------------------------------------------------
   // configuration and table rebuild
   // -------------------------------------------------------------------
   rrv_csr #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_written (cfg_written)
   );

   rrv_builder #(
      .MAX_SEGMENTS     (MAX_SEGMENTS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_builder (
      .clock  (clock),
      .reset  (reset),
      .start  (build_start),
      .cfg    (cfg),
      .tbl_wr (tbl_wr)
   );

   assign build_done = tbl_wr.we && tbl_wr.last;

   // any register write makes the cached offsets stale
   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= 1'b0;
      end else if (cfg_written) begin
         table_valid_ff <= 1'b0;
      end else if (build_done) begin
         table_valid_ff <= 1'b1;
      end
   end

   // -------------------------------------------------------------------
   // offset RAM: {y, x} per vertex slot, one write and one read port
   // -------------------------------------------------------------------
   logic [TBL_DW-1:0] offset_ram [0:TBL_DEPTH-1];
   logic [TBL_DW-1:0] ram_q_ff;
   logic [TBL_AW-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         offset_ram[tbl_wr.addr] <= tbl_wr.data;
      end
      ram_q_ff <= offset_ram[rd_addr];
   end

   // -------------------------------------------------------------------
   // transaction capture: corner centres and run lengths
   // -------------------------------------------------------------------
   logic signed [XY_W-1:0] cx_lo_ff, cx_hi_ff, cy_lo_ff, cy_hi_ff;
   logic [VNUM_W-1:0]      count_last_ff;
   logic [3:0]             pc_last_ff;
   logic signed [XY_W-1:0] rad21;
   logic signed [XY_W-1:0] l21, t21, r21, b21;

   assign req_acc = req_bus.valid && req_ready;
   assign rad21   = {7'b0, cfg.corner_radius, 4'b0000};
   assign l21     = {req_bus.rect_left[COORD_W-1], req_bus.rect_left, 4'b0000};
   assign t21     = {req_bus.rect_top[COORD_W-1], req_bus.rect_top, 4'b0000};
   assign r21     = {req_bus.rect_right[COORD_W-1], req_bus.rect_right, 4'b0000};
   assign b21     = {req_bus.rect_bottom[COORD_W-1], req_bus.rect_bottom, 4'b0000};

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cx_lo_ff <= l21 + rad21;
         cx_hi_ff <= r21 - rad21;
         cy_lo_ff <= t21 + rad21;
         cy_hi_ff <= b21 - rad21;
         if (cfg.frame_mode) begin
            pc_last_ff    <= {cfg.seg_eff, 1'b1};                 // 2(S+1)-1
            count_last_ff <= {cfg.seg_eff, 3'b000} + VNUM_W'(9);  // 8(S+1)+2-1
         end else begin
            pc_last_ff    <= {1'b0, cfg.seg_eff};                 // S
            count_last_ff <= {1'b0, cfg.seg_eff, 2'b11};          // 4(S+1)-1
         end
      end
   end

   // -------------------------------------------------------------------
   // control
   // -------------------------------------------------------------------
   logic              d_vld_ff;
   logic              d_adv;
   logic              o_vld_ff;
   logic              o_adv;
   logic [VNUM_W-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      build_start = 1'b0;
      issue       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               if (table_valid_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in    = ST_BUILD;
                  build_start = 1'b1;
               end
            end
         end
         ST_BUILD: begin
            if (build_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            issue = d_adv;
            if (d_adv && v_ff == count_last_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // hold the RAM until the last read has left the data stage
            if (!d_vld_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_bus.ready = req_ready;

   // -------------------------------------------------------------------
   // emission: read issue -> data stage (RAM output) -> output register
   // -------------------------------------------------------------------
   logic [3:0]        k_ff;
   logic [1:0]        corner_ff;
   logic [TBL_AW-1:0] d_addr_ff;
   logic [1:0]        d_corner_ff;
   logic              d_last_ff;

   assign o_adv = !o_vld_ff || rsp_bus.ready;
   assign d_adv = !d_vld_ff || o_adv;

   // a stalled data stage re-reads its own entry so the RAM output holds
   assign rd_addr = issue ? v_ff : d_addr_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         v_ff      <= '0;
         k_ff      <= '0;
         corner_ff <= CORNER_TL;
      end else if (issue) begin
         v_ff <= v_ff + VNUM_W'(1);
         if (k_ff == pc_last_ff) begin
            k_ff      <= '0;
            corner_ff <= corner_ff + 2'd1;   // wraps to top-left for the frame repeat
         end else begin
            k_ff <= k_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (d_adv) begin
         d_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         d_addr_ff   <= v_ff;
         d_corner_ff <= corner_ff;
         d_last_ff   <= (v_ff == count_last_ff);
      end
   end

   // vertex = corner centre + offset
   logic signed [XY_W-1:0] cx_sel, cy_sel;
   logic signed [XY_W-1:0] off_x, off_y;
   logic signed [XY_W-1:0] o_x_ff, o_y_ff;
   logic [VNUM_W-1:0]      o_num_ff;
   logic                   o_last_ff;

   always_comb begin
      case (d_corner_ff)
         CORNER_TL: begin cx_sel = cx_lo_ff; cy_sel = cy_lo_ff; end
         CORNER_TR: begin cx_sel = cx_hi_ff; cy_sel = cy_lo_ff; end
         CORNER_BR: begin cx_sel = cx_hi_ff; cy_sel = cy_hi_ff; end
         CORNER_BL: begin cx_sel = cx_lo_ff; cy_sel = cy_hi_ff; end
         default:   begin cx_sel = cx_lo_ff; cy_sel = cy_lo_ff; end
      endcase
   end

   assign off_x = {{(XY_W-OFF_W){ram_q_ff[OFF_W-1]}}, ram_q_ff[OFF_W-1:0]};
   assign off_y = {{(XY_W-OFF_W){ram_q_ff[TBL_DW-1]}}, ram_q_ff[TBL_DW-1:OFF_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (o_adv) begin
         o_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_adv) begin
         o_x_ff    <= cx_sel + off_x;
         o_y_ff    <= cy_sel + off_y;
         o_num_ff  <= d_addr_ff;
         o_last_ff <= d_last_ff;
      end
   end

   assign rsp_bus.valid         = o_vld_ff;
   assign rsp_bus.vertex_x      = o_x_ff;
   assign rsp_bus.vertex_y      = o_y_ff;
   assign rsp_bus.vertex_number = o_num_ff;
   assign rsp_bus.last_vertex   = o_last_ff;

   // -------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------
   a_wr_in_build: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.we |-> (state_ff == ST_BUILD))
      else $error("offset RAM written outside a rebuild");

   a_emit_table_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> table_valid_ff)
      else $error("emitting from a stale offset table");

   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !d_vld_ff)
      else $error("transaction accepted with a RAM read still in flight");

   a_data_stage_state: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff |-> (state_ff == ST_EMIT || state_ff == ST_DRAIN))
      else $error("data stage busy outside emission");

endmodule

>>> bench/round_rect_vertex_generator_tb.sv
// Self-checking bench for the rounded-rectangle vertex generator: sends rectangles, programs
// the four registers over APB and checks every outline vertex against its own prediction.
// Depends on rrv_pkg, the rrv_req_if / rrv_rsp_if interfaces and the generator RTL.
module round_rect_vertex_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrv_pkg::*;

   // block parameters and the register defaults after reset
   localparam int SEG_LIMIT      = 6;
   localparam int PHASE_STEPS    = 256;      // sine steps in a quarter turn
   localparam int RING_DEPTH     = 64;       // offset store entries
   localparam logic [RADIUS_W-1:0] DEFAULT_RADIUS = 10'd8;
   localparam logic [SEG_W-1:0]    DEFAULT_SEGS   = 3'd4;
   localparam logic [BORDER_W-1:0] DEFAULT_BORDER = 10'd2;
   localparam logic                DEFAULT_FRAME  = 1'b0;

   // quarter-wave sine polynomial in Q30, odd terms from x^11 down to x
   localparam longint Q30_UNIT = 64'sd1073741824;
   localparam longint SIN_K11  = -64'sd3864;
   localparam longint SIN_K9   = 64'sd172272;
   localparam longint SIN_K7   = -64'sd5026995;
   localparam longint SIN_K5   = 64'sd85569306;
   localparam longint SIN_K3   = -64'sd693598668;
   localparam longint SIN_K1   = 64'sd1686629713;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int PRESSURE_CYCLES = 400;
   localparam int RANDOM_PHASES   = 6;
   localparam int RECTS_PER_PHASE = 17;
   localparam int REPORT_LIMIT    = 10;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   typedef struct {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } rect_type;

   typedef struct {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [VNUM_W-1:0]      number;
      logic                   last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   rrv_req_if rect_bus ();
   rrv_rsp_if vertex_bus ();

   round_rect_vertex_generator #(
      .MAX_SEGMENTS     (SEG_LIMIT),
      .SINE_TABLE_DEPTH (PHASE_STEPS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (rect_bus),
      .rsp_bus     (vertex_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor state: our own copy of the registers and of the cached corner offsets
   // ---------------------------------------------------------------------------------------
   logic [RADIUS_W-1:0] cfg_radius;
   logic [SEG_W-1:0]    cfg_segments;
   logic [BORDER_W-1:0] cfg_border;
   logic                cfg_frame;
   bit                  offsets_stale;
   logic signed [OFF_W-1:0] ring_dx [RING_DEPTH];
   logic signed [OFF_W-1:0] ring_dy [RING_DEPTH];

   vertex_type pending_vertices [$];     // predicted vertices not yet seen on the output

   int error_count;
   int rects_sent;
   int vertices_checked;
   int settings_used;
   int cycle_count;

   // sender burst shaping and receiver stall shaping
   int             burst_left;
   int             gap_max;
   stall_mode_type stall_mode;
   logic [15:0]    stall_bits;
   int             stall_pos;
   int             hold_left;            // long receiver hold-off, counted down below

   // ---------------------------------------------------------------------------------------
   // Fixed-point trigonometry
   // ---------------------------------------------------------------------------------------
   function automatic longint q30_mul(longint a, longint b);
      return (a * b) / Q30_UNIT;         // truncates toward zero
   endfunction

   // sin(pi/2 * x) for x in [0, 1], both in Q30
   function automatic longint quarter_sine(longint x);
      longint x2;
      longint acc;
      x2  = q30_mul(x, x);
      acc = SIN_K11;
      acc = SIN_K9 + q30_mul(acc, x2);
      acc = SIN_K7 + q30_mul(acc, x2);
      acc = SIN_K5 + q30_mul(acc, x2);
      acc = SIN_K3 + q30_mul(acc, x2);
      acc = SIN_K1 + q30_mul(acc, x2);
      return q30_mul(acc, x);
   endfunction

   // t counts quarter turns in steps of 1/PHASE_STEPS; result is Q1.15
   function automatic int sine_q15(int unsigned t);
      int unsigned quadrant;
      int unsigned rem;
      longint      x;
      longint      s;
      int          v;
      quadrant = (t / PHASE_STEPS) % 4;
      rem      = t % PHASE_STEPS;
      x        = (longint'(rem) << 30) / PHASE_STEPS;
      if (quadrant % 2 == 1)
         x = Q30_UNIT - x;
      s = quarter_sine(x);
      if (s < 0)
         s = 0;
      v = int'((s + 16384) / 32768);
      if (v > 32767)
         v = 32767;
      return (quadrant >= 2) ? -v : v;
   endfunction

   // v / 32768 rounded half toward +infinity (a floor of v + half)
   function automatic int round_q15(longint v);
      longint w;
      w = v + 16384;
      if (w >= 0)
         return int'(w / 32768);
      return int'(-((-w + 32767) / 32768));
   endfunction

   // segment count with zero lifted to one and anything above the maximum clipped
   function automatic int unsigned segs_in_use();
      int unsigned s;
      s = 32'(cfg_segments);
      if (s < 1)
         s = 1;
      if (s > SEG_LIMIT)
         s = SEG_LIMIT;
      return s;
   endfunction

   // Recompute the corner offsets. Frame mode interleaves inner (radius less border) and
   // outer points, then repeats the first pair to close the ring.
   function automatic void rebuild_offsets();
      int unsigned s;
      int unsigned n;
      int unsigned p;
      int unsigned t;
      int unsigned slot;
      longint      r_out;
      longint      r_in;
      longint      c;
      longint      sn;
      s     = segs_in_use();
      r_out = longint'(cfg_radius) * 16;
      r_in  = (longint'(cfg_radius) - longint'(cfg_border)) * 16;
      slot  = 0;
      for (int unsigned corner = 0; corner < 4; corner++) begin
         for (int unsigned j = 0; j <= s; j++) begin
            n  = corner * s + j;
            p  = ((n * PHASE_STEPS + 2 * s) / (4 * s)) % PHASE_STEPS;
            t  = 4 * p;
            c  = sine_q15((t + PHASE_STEPS) % (4 * PHASE_STEPS));
            sn = sine_q15(t);
            if (cfg_frame) begin
               ring_dx[slot % RING_DEPTH] = OFF_W'(round_q15(-c * r_in));
               ring_dy[slot % RING_DEPTH] = OFF_W'(round_q15(-sn * r_in));
               slot++;
            end
            ring_dx[slot % RING_DEPTH] = OFF_W'(round_q15(-c * r_out));
            ring_dy[slot % RING_DEPTH] = OFF_W'(round_q15(-sn * r_out));
            slot++;
         end
      end
      if (cfg_frame) begin
         ring_dx[slot % RING_DEPTH]       = ring_dx[0];
         ring_dy[slot % RING_DEPTH]       = ring_dy[0];
         ring_dx[(slot + 1) % RING_DEPTH] = ring_dx[1];
         ring_dy[(slot + 1) % RING_DEPTH] = ring_dy[1];
      end
      offsets_stale = 0;
   endfunction

   // Queue up every vertex one accepted rectangle gives rise to.
   function automatic void predict_outline(rect_type r);
      int          left16;
      int          top16;
      int          right16;
      int          bottom16;
      int          rad;
      int          cx [4];
      int          cy [4];
      int unsigned s;
      int unsigned per_corner;
      int unsigned ring;
      int unsigned count;
      int unsigned corner;
      int          x;
      int          y;
      vertex_type  vtx;
      if (offsets_stale)
         rebuild_offsets();
      left16     = int'(r.left) * 16;
      top16      = int'(r.top) * 16;
      right16    = int'(r.right) * 16;
      bottom16   = int'(r.bottom) * 16;
      rad        = int'(cfg_radius) * 16;
      s          = segs_in_use();
      per_corner = cfg_frame ? 2 * (s + 1) : s + 1;
      ring       = 4 * per_corner;
      count      = cfg_frame ? ring + 2 : ring;
      // corner centres sit one radius inside the bounds, clockwise from top-left
      cx[CORNER_TL] = left16 + rad;   cy[CORNER_TL] = top16 + rad;
      cx[CORNER_TR] = right16 - rad;  cy[CORNER_TR] = top16 + rad;
      cx[CORNER_BR] = right16 - rad;  cy[CORNER_BR] = bottom16 - rad;
      cx[CORNER_BL] = left16 + rad;   cy[CORNER_BL] = bottom16 - rad;
      for (int unsigned v = 0; v < count; v++) begin
         corner     = (v < ring) ? (v / per_corner) % 4 : 32'(CORNER_TL);
         x          = cx[corner] + int'(ring_dx[v % RING_DEPTH]);
         y          = cy[corner] + int'(ring_dy[v % RING_DEPTH]);
         vtx.x      = x[XY_W-1:0];
         vtx.y      = y[XY_W-1:0];
         vtx.number = v[VNUM_W-1:0];
         vtx.last   = (v + 1 == count);
         pending_vertices.push_back(vtx);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------
   function automatic void log_failure(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   // Compare one accepted vertex transaction with the oldest prediction.
   function automatic void check_vertex();
      vertex_type want;
      if (pending_vertices.size() == 0) begin
         log_failure($sformatf("unexpected vertex x=%0d y=%0d n=%0d last=%b",
                     vertex_bus.vertex_x, vertex_bus.vertex_y,
                     vertex_bus.vertex_number, vertex_bus.last_vertex));
         return;
      end
      want = pending_vertices.pop_front();
      vertices_checked++;
      if (vertex_bus.vertex_x !== want.x || vertex_bus.vertex_y !== want.y ||
          vertex_bus.vertex_number !== want.number || vertex_bus.last_vertex !== want.last)
         log_failure($sformatf({"vertex mismatch: expected x=%0d y=%0d n=%0d last=%b, ",
                     "got x=%0d y=%0d n=%0d last=%b"},
                     want.x, want.y, want.number, want.last,
                     vertex_bus.vertex_x, vertex_bus.vertex_y,
                     vertex_bus.vertex_number, vertex_bus.last_vertex));
   endfunction

   // Receiver: checks each vertex transaction, then decides ready for the next edge.
   // Stalls follow a 16-bit mask redrawn each time its position wraps; a hold-off overrides it.
   always @(posedge clock) begin
      if (!reset && vertex_bus.valid && vertex_bus.ready)
         check_vertex();
      if (stall_pos == 0) begin
         case (stall_mode)
            STALL_NONE:  stall_bits = '0;
            STALL_LIGHT: stall_bits = 16'($urandom & $urandom);
            default:     stall_bits = 16'($urandom);
         endcase
      end
      stall_pos = (stall_pos + 1) % 16;
      if (hold_left > 0) begin
         hold_left--;
         vertex_bus.ready <= 1'b0;
      end else begin
         vertex_bus.ready <= !stall_bits[stall_pos];
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d vertices outstanding",
                  cycle_count, pending_vertices.size());
         $display("round_rect_vertex_generator_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Rectangle sender
   // ---------------------------------------------------------------------------------------
   function automatic rect_type make_rect(int l, int t, int r, int b);
      rect_type rect;
      rect.left   = l[COORD_W-1:0];
      rect.top    = t[COORD_W-1:0];
      rect.right  = r[COORD_W-1:0];
      rect.bottom = b[COORD_W-1:0];
      return rect;
   endfunction

   // Mostly ordinary rectangles of modest size; one in four is raw noise on every bit.
   function automatic rect_type random_rect();
      rect_type rect;
      int       l;
      int       t;
      if ($urandom_range(0, 3) == 0) begin
         rect = make_rect($urandom, $urandom, $urandom, $urandom);
      end else begin
         l    = int'($urandom_range(0, 60000)) - 30000;
         t    = int'($urandom_range(0, 60000)) - 30000;
         rect = make_rect(l, t, l + int'($urandom_range(0, 2000)),
                          t + int'($urandom_range(0, 2000)));
      end
      return rect;
   endfunction

   // Offer one rectangle and wait for its transaction. Valid is left high afterwards so that
   // back-to-back rectangles go out without a bubble; gaps come between random bursts.
   task automatic send_rect(rect_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if (gap_max > 0)
            gap = $urandom_range(0, gap_max);
      end
      burst_left--;
      if (gap > 0) begin
         rect_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rect_bus.valid       <= 1'b1;
      rect_bus.rect_left   <= r.left;
      rect_bus.rect_top    <= r.top;
      rect_bus.rect_right  <= r.right;
      rect_bus.rect_bottom <= r.bottom;
      do @(posedge clock); while (!rect_bus.ready);
      predict_outline(r);
      rects_sent++;
   endtask

   task automatic idle_sender();
      if (rect_bus.valid) begin
         rect_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Let every predicted vertex arrive, then let the block settle before returning.
   task automatic wait_for_drain();
      idle_sender();
      while (pending_vertices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Register access
   // ---------------------------------------------------------------------------------------
   function automatic logic [CSR_DW-1:0] register_value(logic [CSR_IDX_W-1:0] idx);
      case (idx)
         REG_CORNER_RADIUS: return CSR_DW'(cfg_radius);
         REG_SEGMENTS:      return CSR_DW'(cfg_segments);
         REG_BORDER_WIDTH:  return CSR_DW'(cfg_border);
         default:           return CSR_DW'(cfg_frame);
      endcase
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DW-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== register_value(idx))
         log_failure($sformatf("register %0d read back %h, expected %h",
                     idx, got, register_value(idx)));
   endtask

   // Write a register (only ever with the block idle), track it, then read it back.
   // Bits above the register width are dropped by the block.
   task automatic program_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
      csr_write(idx, value);
      case (idx)
         REG_CORNER_RADIUS: cfg_radius   = value[RADIUS_W-1:0];
         REG_SEGMENTS:      cfg_segments = value[SEG_W-1:0];
         REG_BORDER_WIDTH:  cfg_border   = value[BORDER_W-1:0];
         default:           cfg_frame    = value[0];
      endcase
      offsets_stale = 1;
      csr_read_check(idx);
   endtask

   task automatic program_all(int radius, int segs, int border, int frame);
      program_register(REG_CORNER_RADIUS, radius);
      program_register(REG_SEGMENTS, segs);
      program_register(REG_BORDER_WIDTH, border);
      program_register(REG_FRAME_MODE, frame);
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Registers read their defaults and the first rectangles use them (filled, S=4).
   task automatic test_reset_defaults();
      csr_read_check(REG_CORNER_RADIUS);
      csr_read_check(REG_SEGMENTS);
      csr_read_check(REG_BORDER_WIDTH);
      csr_read_check(REG_FRAME_MODE);
      settings_used++;
      send_rect(make_rect(0, 0, 100, 50));
      send_rect(make_rect(-20, -20, 20, 20));
      wait_for_drain();
   endtask

   // Bounds at the ends of their range, inverted and degenerate rectangles, alternating bits.
   task automatic test_coordinate_extremes();
      send_rect(make_rect(-32768, -32768, 32767, 32767));
      send_rect(make_rect(32767, 32767, -32768, -32768));
      send_rect(make_rect(0, 0, 0, 0));
      send_rect(make_rect(-1, -1, -1, -1));
      wait_for_drain();
      program_all(1023, 6, 0, 0);
      send_rect(make_rect(-32768, -32768, 32767, 32767));
      send_rect(make_rect('h5555, 'hAAAA, 'hAAAA, 'h5555));
      wait_for_drain();
   endtask

   // Every segment count, including zero (taken as one) and seven (clipped to six).
   task automatic test_segment_clamp();
      program_register(REG_CORNER_RADIUS, 30);
      program_register(REG_BORDER_WIDTH, 5);
      for (int s = 0; s < 8; s++) begin
         program_register(REG_SEGMENTS, s);
         program_register(REG_FRAME_MODE, s % 2);
         settings_used++;
         send_rect(make_rect(-100 + s, -50, 200, 150 - s));
         wait_for_drain();
      end
   endtask

   // Frame pairs, with an inner radius that goes negative, to zero, and the widest ring.
   task automatic test_frame_rings();
      program_all(10, 3, 25, 1);
      send_rect(make_rect(-40, -40, 40, 40));
      wait_for_drain();
      program_all(0, 6, 1023, 1);
      send_rect(make_rect(1000, -1000, 2000, 3000));
      wait_for_drain();
      program_all(1023, 6, 0, 1);
      send_rect(make_rect(-32768, -32768, 32767, 32767));
      wait_for_drain();
      program_all(1023, 2, 1023, 1);
      send_rect(make_rect(-3000, -3000, 3000, 3000));
      wait_for_drain();
   endtask

   // Write data with the upper bits set; only the register width may take effect.
   task automatic test_oversized_writes();
      program_all('hFFFF_FC07, 'hFFFF_FFF8, 'hAAAA_A403, 'hFFFF_FFFE);
      send_rect(make_rect(-5, -5, 5, 5));
      wait_for_drain();
      program_all('h5555_5555, 'hFFFF_FFFD, 'hFFFF_FFFF, 'h8000_0001);
      send_rect(make_rect(12345, -12345, 23456, -2345));
      wait_for_drain();
   endtask

   // Random rectangles across several register settings, with the extremes first.
   function automatic int pick_field(int top_value);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return top_value;
         2:       return $urandom_range(0, 40);
         default: return $urandom_range(0, top_value);
      endcase
   endfunction

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            program_all(1023, 7, 1023, 1);
            stall_mode = STALL_NONE;
            gap_max    = 0;
         end else if (phase == 1) begin
            program_all(0, 0, 0, 0);
            stall_mode = STALL_HEAVY;
            gap_max    = 6;
         end else begin
            program_all(pick_field(1023), $urandom_range(0, 7), pick_field(1023),
                        $urandom_range(0, 1));
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            gap_max    = $urandom_range(0, 6);
         end
         repeat (RECTS_PER_PHASE) send_rect(random_rect());
         wait_for_drain();
      end
   endtask

   // Hold the output off for a long stretch while rectangles keep coming, so the block
   // fills up and has to stall its input; the largest vertex runs make this quickest.
   task automatic test_output_hold_off();
      program_all(100, 6, 20, 1);
      stall_mode = STALL_NONE;
      gap_max    = 0;
      hold_left  = PRESSURE_CYCLES;
      repeat (6) send_rect(random_rect());
      wait_for_drain();
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      rect_bus.valid       = 1'b0;
      rect_bus.rect_left   = '0;
      rect_bus.rect_top    = '0;
      rect_bus.rect_right  = '0;
      rect_bus.rect_bottom = '0;
      vertex_bus.ready     = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      cfg_radius           = DEFAULT_RADIUS;
      cfg_segments         = DEFAULT_SEGS;
      cfg_border           = DEFAULT_BORDER;
      cfg_frame            = DEFAULT_FRAME;
      offsets_stale        = 1;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_dx[i] = '0;
         ring_dy[i] = '0;
      end
      error_count      = 0;
      rects_sent       = 0;
      vertices_checked = 0;
      settings_used    = 0;
      cycle_count      = 0;
      burst_left       = 0;
      gap_max          = 3;
      stall_mode       = STALL_LIGHT;
      stall_bits       = '0;
      stall_pos        = 0;
      hold_left        = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_coordinate_extremes();
      test_segment_clamp();
      test_frame_rings();
      test_oversized_writes();
      test_random_traffic();
      test_output_hold_off();
      wait_for_drain();

      $display("%0d rectangles sent, %0d vertices checked over %0d register settings",
               rects_sent, vertices_checked, settings_used);
      $display("covered filled and frame outlines, every segment count and a long hold-off");
      if (error_count == 0) begin
         $display("round_rect_vertex_generator_tb: done, clean");
      end else begin
         $display("%0d failures", error_count);
         $display("round_rect_vertex_generator_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rrv_pkg.sv
hw/rtl/rrv_if.sv
hw/rtl/rrv_csr.sv
hw/rtl/rrv_builder.sv
hw/rtl/round_rect_vertex_generator.sv
bench/round_rect_vertex_generator_tb.sv
